>>> rtl/ctgwa_pkg.sv
// Package for the cell-to-grain weighted average block.
// Holds field widths, payload structs, register indexes and the sequencer states.
// No dependencies.
package ctgwa_pkg;

    localparam int MAX_GRAIN_CELLS = 1024;
    localparam int STATE_BITS      = 32;
    localparam int ENERGY_BITS     = 20;

    localparam int TOTAL_W   = 16;
    localparam int GSIZE_W   = 11;
    localparam int OFFSET_W  = 10;
    localparam int PROD_W    = STATE_BITS + ENERGY_BITS;
    localparam int SUM_W     = 42;
    localparam int WSUM_W    = 62;
    localparam int MEAN_W    = 20;
    localparam int COUNT_W   = 16;
    localparam int DIV_CNT_W = 5;

    localparam logic [1:0] REG_CELL_TOTAL      = 2'd0;
    localparam logic [1:0] REG_CELLS_PER_GRAIN = 2'd1;
    localparam logic [1:0] REG_FIRST_OFFSET    = 2'd2;

    typedef struct packed {
        logic [STATE_BITS-1:0]  cell_states;
        logic [ENERGY_BITS-1:0] cell_energy;
    } cell_t;

    typedef struct packed {
        logic [SUM_W-1:0]   grain_states;
        logic [MEAN_W-1:0]  grain_mean_energy;
        logic [COUNT_W-1:0] grain_slot;
        logic               has_states;
        logic               last_grain;
        logic               short_of_request;
    } grain_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_ACC,
        S_EVAL,
        S_CHK,
        S_DIV,
        S_OUT,
        S_WLOAD
    } seq_state_t;

endpackage

>>> rtl/cell_to_grain_weighted_average.sv
// Cell-to-grain weighted average: bins a cell stream into grains, gives state sum
// and state-weighted mean energy per grain. Depends on ctgwa_pkg.
//
//  channel   signals                                   direction  payload
//  cell      cell_valid / cell_stall / cell_item       in         cell_t
//  grain     grain_valid / grain_stall / grain         out        grain_t
//  config    cfg_valid / cfg_ready / cfg_index         in         cfg_data (16 bits)
//
// A cell goes through capture, multiply, accumulate and evaluate. A grain close adds
// an output step, preceded by a saturation check unless the grain is empty, and by a
// divide unless the mean saturates: one shared compare/subtract divider stepping one
// quotient bit a cycle (saturation check plus 20 bits). A write to a known register
// runs it as well to work out the grain count. Reset is asynchronous, active low, and
// loads the default config. The cell input stalls while a config write is offered.
// A stalled result sits in the output register; a new cell is still taken, and
// the sequencer waits only when the next result finds that register full.
module cell_to_grain_weighted_average
    import ctgwa_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cell_valid,
    output logic                cell_stall,
    input  cell_t               cell_item,
    output logic                grain_valid,
    input  logic                grain_stall,
    output grain_t              grain,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [TOTAL_W-1:0]  cfg_data
);

    localparam logic [GSIZE_W-1:0]   GSIZE_MAX = GSIZE_W'(MAX_GRAIN_CELLS);
    localparam logic [MEAN_W-1:0]    MEAN_MAX  = '1;
    localparam logic [DIV_CNT_W-1:0] MEAN_STEPS_M1 = DIV_CNT_W'(MEAN_W - 1);
    localparam logic [DIV_CNT_W-1:0] WANT_STEPS_M1 = DIV_CNT_W'(COUNT_W - 1);

    seq_state_t state_reg, state_next;

    logic [TOTAL_W-1:0]     cell_total_reg, cell_total_next;
    logic [GSIZE_W-1:0]     cpg_reg, cpg_next;
    logic [OFFSET_W-1:0]    offset_reg, offset_next;

    logic [STATE_BITS-1:0]  st_reg, st_next;
    logic [ENERGY_BITS-1:0] en_reg, en_next;
    logic [PROD_W-1:0]      prod_reg, prod_next;
    logic [SUM_W-1:0]       sum_reg, sum_next;
    logic [WSUM_W-1:0]      wsum_reg, wsum_next;
    logic [GSIZE_W-1:0]     cells_left_reg, cells_left_next;
    logic [COUNT_W-1:0]     seen_reg, seen_next;
    logic [COUNT_W-1:0]     closed_reg, closed_next;
    logic [COUNT_W-1:0]     stored_reg, stored_next;
    logic [COUNT_W-1:0]     want_reg, want_next;
    logic                   close_reg, close_next;

    logic [WSUM_W-1:0]      rem_reg, rem_next;
    logic [WSUM_W-1:0]      dvs_reg, dvs_next;
    logic [MEAN_W-1:0]      quo_reg, quo_next;
    logic [DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic                   div_want_reg, div_want_next;

    grain_t                 grain_reg, grain_next;
    logic                   grain_valid_reg, grain_valid_next;

    logic [GSIZE_W-1:0]     gsize;
    logic [GSIZE_W-1:0]     off_clamped;
    logic [GSIZE_W-1:0]     first_len;
    logic                   div_ge;
    logic [WSUM_W-1:0]      div_diff;
    logic [MEAN_W-1:0]      quo_shift;
    logic                   cell_take;
    logic                   cfg_take;
    logic                   cfg_known;
    logic                   out_free;
    logic                   active;
    logic [COUNT_W-1:0]     closed_inc;
    logic [COUNT_W-1:0]     stored_inc;
    logic                   nonempty;
    logic                   last;

    // grain geometry from the config registers
    always_comb
    begin
        if (cpg_reg == '0)
            gsize = GSIZE_W'(1);
        else if (cpg_reg > GSIZE_MAX)
            gsize = GSIZE_MAX;
        else
            gsize = cpg_reg;
        if (GSIZE_W'(offset_reg) >= gsize)
            off_clamped = gsize - GSIZE_W'(1);
        else
            off_clamped = GSIZE_W'(offset_reg);
        first_len = gsize - off_clamped;
    end

    // shared divider compare/subtract
    assign div_ge    = rem_reg >= dvs_reg;
    assign div_diff  = rem_reg - dvs_reg;
    assign quo_shift = {quo_reg[MEAN_W-2:0], div_ge};

    assign cell_stall  = (state_reg != S_IDLE) || cfg_valid;
    assign cfg_ready   = (state_reg == S_IDLE);
    assign grain_valid = grain_valid_reg;
    assign grain       = grain_reg;

    assign cell_take  = cell_valid && !cell_stall;
    assign cfg_take   = cfg_valid && cfg_ready;
    assign cfg_known  = (cfg_index == REG_CELL_TOTAL) || (cfg_index == REG_CELLS_PER_GRAIN)
                        || (cfg_index == REG_FIRST_OFFSET);
    assign out_free   = !grain_valid_reg || !grain_stall;
    assign active     = closed_reg < want_reg;
    assign closed_inc = closed_reg + COUNT_W'(1);
    assign stored_inc = stored_reg + COUNT_W'(1);
    assign nonempty   = (sum_reg != '0);
    assign last       = (closed_inc == want_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cfg_take && cfg_known)
                    state_next = S_WLOAD;
                else if (cell_take)
                    state_next = S_MUL;
            end
            S_MUL:   state_next = S_ACC;
            S_ACC:   state_next = S_EVAL;
            S_EVAL:
            begin
                if (!close_reg)
                    state_next = S_IDLE;
                else if (nonempty)
                    state_next = S_CHK;
                else
                    state_next = S_OUT;
            end
            S_CHK:   state_next = div_ge ? S_OUT : S_DIV;
            S_DIV:
            begin
                if (cnt_reg == '0)
                    state_next = div_want_reg ? S_IDLE : S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            S_WLOAD: state_next = S_DIV;
            default: state_next = S_IDLE;
        endcase
    end

    // datapath
    always_comb
    begin
        cell_total_next  = cell_total_reg;
        cpg_next         = cpg_reg;
        offset_next      = offset_reg;
        st_next          = st_reg;
        en_next          = en_reg;
        prod_next        = prod_reg;
        sum_next         = sum_reg;
        wsum_next        = wsum_reg;
        cells_left_next  = cells_left_reg;
        seen_next        = seen_reg;
        closed_next      = closed_reg;
        stored_next      = stored_reg;
        want_next        = want_reg;
        close_next       = close_reg;
        rem_next         = rem_reg;
        dvs_next         = dvs_reg;
        quo_next         = quo_reg;
        cnt_next         = cnt_reg;
        div_want_next    = div_want_reg;
        grain_next       = grain_reg;
        grain_valid_next = grain_valid_reg;

        if (grain_valid_reg && !grain_stall)
            grain_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cfg_take)
                begin
                    unique case (cfg_index)
                        REG_CELL_TOTAL:      cell_total_next = cfg_data;
                        REG_CELLS_PER_GRAIN: cpg_next = cfg_data[GSIZE_W-1:0];
                        REG_FIRST_OFFSET:    offset_next = cfg_data[OFFSET_W-1:0];
                        default:             cell_total_next = cell_total_reg;
                    endcase
                end
                else if (cell_take)
                begin
                    st_next = cell_item.cell_states;
                    en_next = cell_item.cell_energy;
                end
            end
            S_MUL:
            begin
                prod_next = PROD_W'(st_reg) * PROD_W'(en_reg);
            end
            S_ACC:
            begin
                if (seen_reg != '1)
                    seen_next = seen_reg + COUNT_W'(1);
                close_next = active && (cells_left_reg <= GSIZE_W'(1));
                if (active)
                begin
                    sum_next  = sum_reg + SUM_W'(st_reg);
                    wsum_next = wsum_reg + WSUM_W'(prod_reg);
                    if (cells_left_reg != '0)
                        cells_left_next = cells_left_reg - GSIZE_W'(1);
                end
            end
            S_EVAL:
            begin
                if (close_reg)
                begin
                    quo_next      = '0;
                    rem_next      = wsum_reg;
                    dvs_next      = {sum_reg, {MEAN_W{1'b0}}};
                    div_want_next = 1'b0;
                end
                else if (closed_reg >= want_reg && seen_reg >= cell_total_reg)
                begin
                    cells_left_next = first_len;
                    closed_next     = '0;
                    stored_next     = '0;
                    sum_next        = '0;
                    wsum_next       = '0;
                    seen_next       = '0;
                end
            end
            S_CHK:
            begin
                // mean of 2^20 or more saturates
                if (div_ge)
                    quo_next = MEAN_MAX;
                else
                begin
                    dvs_next = dvs_reg >> 1;
                    cnt_next = MEAN_STEPS_M1;
                end
            end
            S_DIV:
            begin
                if (div_ge)
                    rem_next = div_diff;
                quo_next = quo_shift;
                dvs_next = dvs_reg >> 1;
                cnt_next = cnt_reg - DIV_CNT_W'(1);
                if (cnt_reg == '0 && div_want_reg)
                    want_next = quo_shift[COUNT_W-1:0];
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    grain_next.grain_states      = sum_reg;
                    grain_next.grain_mean_energy = nonempty ? quo_reg : '0;
                    grain_next.grain_slot        = nonempty ? stored_reg : '0;
                    grain_next.has_states        = nonempty;
                    grain_next.last_grain        = last;
                    grain_next.short_of_request  =
                        last && ((nonempty ? stored_inc : stored_reg) < want_reg);
                    grain_valid_next = 1'b1;
                    if (closed_inc >= want_reg && seen_reg >= cell_total_reg)
                    begin
                        cells_left_next = first_len;
                        closed_next     = '0;
                        stored_next     = '0;
                        seen_next       = '0;
                    end
                    else
                    begin
                        cells_left_next = gsize;
                        closed_next     = closed_inc;
                        if (nonempty)
                            stored_next = stored_inc;
                    end
                    sum_next  = '0;
                    wsum_next = '0;
                end
            end
            S_WLOAD:
            begin
                // grain count = cell_total / grain size, 16 quotient bits
                rem_next        = WSUM_W'(cell_total_reg);
                dvs_next        = WSUM_W'({gsize, {(COUNT_W-1){1'b0}}});
                quo_next        = '0;
                cnt_next        = WANT_STEPS_M1;
                div_want_next   = 1'b1;
                cells_left_next = first_len;
                closed_next     = '0;
                stored_next     = '0;
                sum_next        = '0;
                wsum_next       = '0;
                seen_next       = '0;
            end
            default:
            begin
                quo_next = quo_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            cell_total_reg  <= TOTAL_W'(1024);
            cpg_reg         <= GSIZE_W'(1);
            offset_reg      <= '0;
            sum_reg         <= '0;
            wsum_reg        <= '0;
            cells_left_reg  <= GSIZE_W'(1);
            seen_reg        <= '0;
            closed_reg      <= '0;
            stored_reg      <= '0;
            want_reg        <= COUNT_W'(1024);
            close_reg       <= 1'b0;
            cnt_reg         <= '0;
            div_want_reg    <= 1'b0;
            grain_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            cell_total_reg  <= cell_total_next;
            cpg_reg         <= cpg_next;
            offset_reg      <= offset_next;
            sum_reg         <= sum_next;
            wsum_reg        <= wsum_next;
            cells_left_reg  <= cells_left_next;
            seen_reg        <= seen_next;
            closed_reg      <= closed_next;
            stored_reg      <= stored_next;
            want_reg        <= want_next;
            close_reg       <= close_next;
            cnt_reg         <= cnt_next;
            div_want_reg    <= div_want_next;
            grain_valid_reg <= grain_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        st_reg    <= st_next;
        en_reg    <= en_next;
        prod_reg  <= prod_next;
        rem_reg   <= rem_next;
        dvs_reg   <= dvs_next;
        quo_reg   <= quo_next;
        grain_reg <= grain_next;
    end

endmodule

>>> verif/tb_cell_to_grain_weighted_average.sv
`timescale 1ns / 100ps
// Testbench for cell_to_grain_weighted_average: a directed table, then random config phases,
// every grain transaction checked against a typed table row or an in-bench binning predictor.
// Depends on ctgwa_pkg and the block's RTL.
module tb_cell_to_grain_weighted_average;
    import ctgwa_pkg::*;

    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 40;
    localparam int TARGET_CELLS = 1150;
    localparam logic [MEAN_W-1:0] MEAN_SAT = '1;

    typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_LONG} stall_mode_t;

    typedef struct {
        bit                  is_reg;
        logic [1:0]          idx;
        logic [TOTAL_W-1:0]  val;
        cell_t               c;
        bit                  typed;
        grain_t              want;
    } dir_row_t;

    logic                clk;
    logic                rst_n;
    logic                cell_valid;
    logic                cell_stall;
    cell_t               cell_item;
    logic                grain_valid;
    logic                grain_stall = 1'b0;
    grain_t              grain;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [1:0]          cfg_index;
    logic [TOTAL_W-1:0]  cfg_data;

    cell_to_grain_weighted_average dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cell_valid  (cell_valid),
        .cell_stall  (cell_stall),
        .cell_item   (cell_item),
        .grain_valid (grain_valid),
        .grain_stall (grain_stall),
        .grain       (grain),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // predictor state
    logic [TOTAL_W-1:0]  tot_reg;
    logic [GSIZE_W-1:0]  gsize_reg;
    logic [OFFSET_W-1:0] offset_reg;
    int unsigned         cells_to_close;
    int unsigned         closed_cnt;
    int unsigned         stored_cnt;
    int unsigned         batch_cells;
    logic [SUM_W-1:0]    acc_states;
    logic [WSUM_W-1:0]   acc_weighted;

    grain_t      grain_expect[$];
    dir_row_t    dir_rows[$];
    int          errors = 0;
    int          n_cells;
    int          n_grains = 0;
    int          n_empty = 0;
    int          n_writes;
    int          n_phases;
    int          burst_left;
    int          gap_max;
    stall_mode_t stall_mode = STALL_NONE;
    int          stall_left = 0;

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial begin
        #1_000_000;
        $display("** cell_to_grain_weighted_average: FAILED **");
        $finish;
    end

    function automatic int unsigned eff_gsize();
        int unsigned g;
        g = gsize_reg;
        if (g == 0) g = 1;
        if (g > MAX_GRAIN_CELLS) g = MAX_GRAIN_CELLS;
        return g;
    endfunction

    function automatic int unsigned grains_wanted();
        return tot_reg / eff_gsize();
    endfunction

    function automatic void restart_batch();
        int unsigned g;
        int unsigned off;
        g = eff_gsize();
        off = offset_reg;
        if (off >= g) off = g - 1;
        cells_to_close = g - off;
        closed_cnt = 0;
        stored_cnt = 0;
        batch_cells = 0;
        acc_states = '0;
        acc_weighted = '0;
    endfunction

    function automatic void write_model_reg(logic [1:0] idx, logic [TOTAL_W-1:0] val);
        case (idx)
            REG_CELL_TOTAL:      tot_reg = val;
            REG_CELLS_PER_GRAIN: gsize_reg = val[GSIZE_W-1:0];
            REG_FIRST_OFFSET:    offset_reg = val[OFFSET_W-1:0];
            default:             return;
        endcase
        restart_batch();
    endfunction

    // Bins one accepted cell; returns 1 when it closes a grain.
    function automatic bit bin_cell(input cell_t c, output grain_t g);
        logic [PROD_W-1:0] prod;
        logic [WSUM_W-1:0] mean;
        int unsigned       want;
        bit                made;
        made = 1'b0;
        g = '0;
        want = grains_wanted();
        prod = PROD_W'(c.cell_states) * PROD_W'(c.cell_energy);
        if (batch_cells != 32'hFFFF_FFFF) batch_cells++;
        if (closed_cnt < want) begin
            acc_states = acc_states + SUM_W'(c.cell_states);
            acc_weighted = acc_weighted + WSUM_W'(prod);
            if (cells_to_close > 0) cells_to_close--;
            if (cells_to_close == 0) begin
                if (acc_states != 0) begin
                    mean = acc_weighted / WSUM_W'(acc_states);
                    g.grain_states = acc_states;
                    g.grain_mean_energy = (mean > WSUM_W'(MEAN_SAT)) ? MEAN_SAT
                                                                     : mean[MEAN_W-1:0];
                    g.grain_slot = stored_cnt[COUNT_W-1:0];
                    g.has_states = 1'b1;
                    stored_cnt++;
                end
                closed_cnt++;
                g.last_grain = (closed_cnt == want);
                g.short_of_request = g.last_grain && (stored_cnt < want);
                made = 1'b1;
                acc_states = '0;
                acc_weighted = '0;
                cells_to_close = eff_gsize();
            end
        end
        if (closed_cnt >= want && batch_cells >= tot_reg) restart_batch();
        return made;
    endfunction

    function automatic dir_row_t reg_row(logic [1:0] idx, logic [TOTAL_W-1:0] val);
        dir_row_t r;
        r.is_reg = 1'b1;
        r.idx = idx;
        r.val = val;
        r.c = '0;
        r.typed = 1'b0;
        r.want = '0;
        return r;
    endfunction

    function automatic dir_row_t cell_row(logic [STATE_BITS-1:0] st, logic [ENERGY_BITS-1:0] en);
        dir_row_t r;
        r.is_reg = 1'b0;
        r.idx = REG_CELL_TOTAL;
        r.val = '0;
        r.c.cell_states = st;
        r.c.cell_energy = en;
        r.typed = 1'b0;
        r.want = '0;
        return r;
    endfunction

    function automatic dir_row_t typed_row(logic [STATE_BITS-1:0] st, logic [ENERGY_BITS-1:0] en,
                                           logic [SUM_W-1:0] gs, logic [MEAN_W-1:0] me,
                                           logic [COUNT_W-1:0] sl, bit hs, bit lg, bit sh);
        dir_row_t r;
        r = cell_row(st, en);
        r.typed = 1'b1;
        r.want.grain_states = gs;
        r.want.grain_mean_energy = me;
        r.want.grain_slot = sl;
        r.want.has_states = hs;
        r.want.last_grain = lg;
        r.want.short_of_request = sh;
        return r;
    endfunction

    function automatic cell_t rand_cell(int zero_pct);
        cell_t c;
        if ($urandom_range(0, 99) < zero_pct) c.cell_states = '0;
        else begin
            case ($urandom_range(0, 3))
                0:       c.cell_states = '1;
                1:       c.cell_states = STATE_BITS'($urandom_range(1, 255));
                default: c.cell_states = STATE_BITS'($urandom);
            endcase
        end
        case ($urandom_range(0, 4))
            0:       c.cell_energy = '0;
            1:       c.cell_energy = '1;
            default: c.cell_energy = ENERGY_BITS'($urandom);
        endcase
        return c;
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
        end
    endfunction

    // entered at a falling edge, returns at one
    task automatic send_cell(input cell_t c, input bit typed, input grain_t want);
        grain_t g;
        cell_valid <= 1'b1;
        cell_item <= c;
        do @(posedge clk); while (cell_stall);
        if (bin_cell(c, g)) grain_expect.push_back(typed ? want : g);
        n_cells++;
        @(negedge clk);
        if (gap_max > 0) begin
            if (burst_left == 0) begin
                cell_valid <= 1'b0;
                repeat ($urandom_range(1, gap_max)) @(negedge clk);
                burst_left = $urandom_range(1, 24);
            end
            else burst_left--;
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [TOTAL_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        write_model_reg(idx, val);
        n_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // all grains in, then room for cells that close nothing
    task automatic settle();
        while (grain_expect.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    always @(negedge clk) begin
        if (stall_left == 0) begin
            stall_mode = stall_mode_t'($urandom_range(0, 3));
            stall_left = $urandom_range(8, 80);
        end
        else stall_left--;
        case (stall_mode)
            STALL_NONE:  grain_stall <= 1'b0;
            STALL_LIGHT: grain_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: grain_stall <= ($urandom_range(0, 1) == 0);
            default:     grain_stall <= (stall_left % 20) < 12;
        endcase
    end

    always @(posedge clk) begin : grain_check
        grain_t exp_g;
        if (rst_n && grain_valid && !grain_stall) begin
            if (grain_expect.size() == 0) begin
                $error("unexpected grain transaction: %p", grain);
                errors++;
            end
            else begin
                exp_g = grain_expect.pop_front();
                n_grains++;
                if (!exp_g.has_states) n_empty++;
                check_field("grain_states", exp_g.grain_states, grain.grain_states);
                check_field("grain_mean_energy", exp_g.grain_mean_energy,
                            grain.grain_mean_energy);
                check_field("grain_slot", exp_g.grain_slot, grain.grain_slot);
                check_field("has_states", exp_g.has_states, grain.has_states);
                check_field("last_grain", exp_g.last_grain, grain.last_grain);
                check_field("short_of_request", exp_g.short_of_request,
                            grain.short_of_request);
            end
        end
    end

    initial begin
        logic [1:0]         regs [3];
        logic [TOTAL_W-1:0] vals [3];
        int                 start;
        int                 n;
        int                 zero_pct;

        cell_valid = 1'b0;
        cell_item = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_CELL_TOTAL;
        cfg_data = '0;
        n_cells = 0;
        n_writes = 0;
        n_phases = 0;
        burst_left = 0;
        gap_max = 3;
        tot_reg = 16'd1024;
        gsize_reg = 11'd1;
        offset_reg = '0;
        restart_batch();
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset config: every cell is a grain of its own
        dir_rows.push_back(typed_row(32'hFFFF_FFFF, 20'hF_FFFF, 42'hFFFF_FFFF, 20'hF_FFFF,
                                     16'd0, 1, 0, 0));
        dir_rows.push_back(typed_row(32'h0, 20'hF_FFFF, 42'h0, 20'h0, 16'd0, 0, 0, 0));
        dir_rows.push_back(typed_row(32'h1, 20'h0, 42'h1, 20'h0, 16'd1, 1, 0, 0));
        dir_rows.push_back(typed_row(32'h8000_0000, 20'h8_0000, 42'h8000_0000, 20'h8_0000,
                                     16'd2, 1, 0, 0));
        dir_rows.push_back(cell_row(32'h7FFF_FFFF, 20'h7_FFFF));
        // three grains, last one short, next batch starts at once
        dir_rows.push_back(reg_row(REG_CELL_TOTAL, 16'd3));
        dir_rows.push_back(typed_row(32'd5, 20'd10, 42'd5, 20'd10, 16'd0, 1, 0, 0));
        dir_rows.push_back(typed_row(32'd0, 20'd3, 42'd0, 20'd0, 16'd0, 0, 0, 0));
        dir_rows.push_back(typed_row(32'd0, 20'h1_2345, 42'd0, 20'd0, 16'd0, 0, 1, 1));
        dir_rows.push_back(typed_row(32'd2, 20'd7, 42'd2, 20'd7, 16'd0, 1, 0, 0));
        // grain size zero acts as one
        dir_rows.push_back(reg_row(REG_CELLS_PER_GRAIN, 16'd0));
        dir_rows.push_back(typed_row(32'd9, 20'd1, 42'd9, 20'd1, 16'd0, 1, 0, 0));
        // oversized grain: nothing requested, all tail
        dir_rows.push_back(reg_row(REG_CELLS_PER_GRAIN, 16'hFFFF));
        dir_rows.push_back(cell_row(32'd4, 20'd4));
        dir_rows.push_back(cell_row(32'hFFFF_FFFF, 20'hF_FFFF));
        dir_rows.push_back(reg_row(REG_CELL_TOTAL, 16'd0));
        dir_rows.push_back(cell_row(32'd1, 20'd1));
        // offset clamped: one-cell first grain, then tail
        dir_rows.push_back(reg_row(REG_CELL_TOTAL, 16'd4));
        dir_rows.push_back(reg_row(REG_CELLS_PER_GRAIN, 16'd4));
        dir_rows.push_back(reg_row(REG_FIRST_OFFSET, 16'hFFFF));
        dir_rows.push_back(typed_row(32'd3, 20'd100, 42'd3, 20'd100, 16'd0, 1, 1, 0));
        dir_rows.push_back(cell_row(32'd1, 20'd2));
        dir_rows.push_back(reg_row(REG_UNUSED, 16'hFFFF));
        dir_rows.push_back(cell_row(32'd8, 20'd8));
        dir_rows.push_back(cell_row(32'd0, 20'd0));
        dir_rows.push_back(typed_row(32'd6, 20'hF_FFFF, 42'd6, 20'hF_FFFF, 16'd0, 1, 1, 0));

        @(negedge clk);
        foreach (dir_rows[i]) begin
            if (dir_rows[i].is_reg) begin
                cell_valid <= 1'b0;
                settle();
                write_reg(dir_rows[i].idx, dir_rows[i].val);
            end
            else send_cell(dir_rows[i].c, dir_rows[i].typed, dir_rows[i].want);
        end

        regs[0] = REG_CELL_TOTAL;
        regs[1] = REG_CELLS_PER_GRAIN;
        regs[2] = REG_FIRST_OFFSET;
        while (n_cells < TARGET_CELLS) begin
            case (n_phases)
                0: begin vals[0] = 16'hFFFF; vals[1] = 16'd1;    vals[2] = 16'd0;    end
                1: begin vals[0] = 16'hFFFF; vals[1] = 16'd2047; vals[2] = 16'd1023; end
                2: begin vals[0] = 16'd1;    vals[1] = 16'd1;    vals[2] = 16'd0;    end
                3: begin vals[0] = 16'd2047; vals[1] = 16'd1024; vals[2] = 16'd1000; end
                default: begin
                    case ($urandom_range(0, 9))
                        0:       vals[0] = 16'($urandom_range(0, 3));
                        1:       vals[0] = 16'hFFFF;
                        default: vals[0] = 16'($urandom_range(1, 120));
                    endcase
                    case ($urandom_range(0, 19))
                        0, 1:    vals[1] = 16'd0;
                        2:       vals[1] = 16'($urandom_range(1025, 2047));
                        3:       vals[1] = 16'd1024;
                        default: vals[1] = 16'($urandom_range(1, 8));
                    endcase
                    case ($urandom_range(0, 19))
                        0, 1, 2: vals[2] = 16'($urandom_range(0, 1023));
                        3, 4, 5, 6, 7: vals[2] = 16'($urandom_range(0, 8));
                        default: vals[2] = 16'd0;
                    endcase
                    // upper bits beyond the register width are don't-care
                    if ($urandom_range(0, 3) == 0) vals[1][15:GSIZE_W] = 5'($urandom);
                    if ($urandom_range(0, 3) == 0) vals[2][15:OFFSET_W] = 6'($urandom);
                end
            endcase
            cell_valid <= 1'b0;
            settle();
            start = $urandom_range(0, 2);
            for (int k = 0; k < 3; k++) write_reg(regs[(start + k) % 3], vals[(start + k) % 3]);
            if ($urandom_range(0, 4) == 0) write_reg(REG_UNUSED, 16'($urandom));
            gap_max = (n_phases == 0 || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            zero_pct = $urandom_range(0, 60);
            n = $urandom_range(30, 90);
            repeat (n) send_cell(rand_cell(zero_pct), 1'b0, '0);
            n_phases++;
        end

        cell_valid <= 1'b0;
        settle();
        $display("ran %0d cells over %0d random config phases with %0d register writes",
                 n_cells, n_phases, n_writes);
        $display("checked %0d grains (%0d empty), %0d mismatches", n_grains, n_empty, errors);
        if (errors == 0)
            $display("** cell_to_grain_weighted_average: PASSED **");
        else
            $display("** cell_to_grain_weighted_average: FAILED **");
        $finish;
    end

endmodule
